[hw/rtl/cfd_pkg.sv]
// ---------------------------------------------------------------------------
// cfd_pkg - shared definitions for the checked frame demultiplexer
// Record codes, ASCII constants, default sizes and the hex digit decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int unsigned MAX_CHANNEL_DEF = 9;
  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  // Fixed field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned CNT32_W  = 32;
  localparam int unsigned CHUNK_LEN = 7;
  localparam int unsigned CHUNK_W  = CHUNK_LEN * BYTE_W;
  localparam int unsigned OUT_DATA_W = 160;

  // ASCII constants
  localparam logic [BYTE_W-1:0] LINE_END  = 8'h0A;
  localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'h3F;
  localparam logic [BYTE_W-1:0] ASCII_0   = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_9   = 8'h39;
  localparam logic [BYTE_W-1:0] ASCII_UA  = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_UF  = 8'h46;
  localparam logic [BYTE_W-1:0] ASCII_LA  = 8'h61;
  localparam logic [BYTE_W-1:0] ASCII_LF  = 8'h66;

  localparam logic [CHUNK_W-1:0] ALL_PAD = {CHUNK_LEN{PAD_BYTE}};
  localparam logic [CNT32_W-1:0] SAT32   = '1;

  // Input request kinds
  localparam logic IN_DATA = 1'b0;
  localparam logic IN_EOS  = 1'b1;

  // Result record kinds
  typedef enum logic [KIND_W-1:0] {
    REC_VALID    = 3'd0,
    REC_REJECTED = 3'd1,
    REC_STOP     = 3'd2,
    REC_BAD_CHAN = 3'd3,
    REC_TOO_LONG = 3'd4
  } rec_kind_t;

  // Decode a hex digit: bit 4 flags a legal digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= ASCII_0 && c <= ASCII_9) begin
      res = {1'b1, 4'(c - ASCII_0)};
    end else if (c >= ASCII_UA && c <= ASCII_UF) begin
      res = {1'b1, 4'(c - ASCII_UA + 8'd10)};
    end else if (c >= ASCII_LA && c <= ASCII_LF) begin
      res = {1'b1, 4'(c - ASCII_LA + 8'd10)};
    end
    return res;
  endfunction

  // Saturating 32-bit add of a small increment
  function automatic logic [CNT32_W-1:0] sat_add(input logic [CNT32_W-1:0] a,
                                                 input logic [3:0] b);
    logic [CNT32_W:0] s;
    s = {1'b0, a} + {{(CNT32_W-3){1'b0}}, b};
    return s[CNT32_W] ? SAT32 : s[CNT32_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/checked_frame_demultiplexer.sv]
// ---------------------------------------------------------------------------
// checked_frame_demultiplexer - newline framed stream to per-channel chunks
// Checks each line's hex check digit against its payload length and sends
// the payload out in 7-byte chunks on the line's channel, or raw on channel 0.
// ---------------------------------------------------------------------------
// Input requests are single bytes (in_tuser = 0) or an end-of-stream marker
// (in_tuser = 1). A line is a channel digit, payload bytes and a hex check
// digit, closed by a line feed. Ordinary bytes are taken one per cycle while
// the output slot is free, and the payload is written into a single-port
// payload memory of MAX_PAYLOAD bytes. At a line feed the block stops taking
// requests while it reads the payload back: each chunk of up to 7 bytes costs
// one memory read per byte in S_FILL, a wait in S_LAND for the last read to
// land and a load of the output register in S_PUSH, which also waits on
// out_tready. Stop, bad channel code and frame too long results are produced
// straight from the accepting cycle. Every result carries the running frame
// and invalid frame counters, chunk results also the channel counter, all
// saturating at 2^32 - 1. The payload memory needs no initialization after
// reset: only entries written by the current line are ever read.
// ---------------------------------------------------------------------------
`default_nettype none

module checked_frame_demultiplexer
  import cfd_pkg::*;
#(
  parameter int unsigned MAX_CHANNEL = MAX_CHANNEL_DEF,
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [BYTE_W-1:0]     in_tdata,   // [7:0] byte_in
  input  wire logic                  in_tuser,   // [0] kind
  // Result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [3:0] channel, [59:4] chunk_bytes,
                                                 // [62:60] byte_count,
                                                 // [94:63] channel_total,
                                                 // [126:95] frames_total,
                                                 // [158:127] frames_invalid, [159] zero
  output logic [KIND_W-1:0]          out_tuser,  // [2:0] record_kind
  output logic                       out_tlast   // last
);

  localparam int unsigned LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_PAYLOAD);
  localparam int unsigned NCHAN  = MAX_CHANNEL + 1;
  localparam int unsigned CIDX_W = (NCHAN > 1) ? $clog2(NCHAN) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_LAND,
    S_PUSH
  } state_t;

  state_t state_r;

  // Line assembly state
  logic                  have_chan_r;
  logic [CHAN_W-1:0]     chan_code_r;
  logic [BYTE_W-1:0]     held_byte_r;
  logic                  held_valid_r;
  logic                  drop_line_r;
  logic [LEN_W-1:0]      len_r;

  // Counters
  logic [CNT32_W-1:0]    frames_r;
  logic [CNT32_W-1:0]    invalid_r;
  logic [CNT32_W-1:0]    chan_cnt_r [NCHAN];

  // Chunk readout
  logic [LEN_W-1:0]      emit_len_r;
  logic                  emit_ok_r;
  logic [CHAN_W-1:0]     emit_ch_r;
  logic [LEN_W-1:0]      fill_idx_r;
  logic [COUNT_W-1:0]    fill_pos_r;
  logic                  land_r;
  logic [COUNT_W-1:0]    land_pos_r;
  logic [CHUNK_W-1:0]    chunk_r;

  // Payload memory
  logic [BYTE_W-1:0]     payload_mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0]     mem_q_r;

  // Output register
  logic                  out_valid_r;
  rec_kind_t             out_kind_r;
  logic [CHAN_W-1:0]     out_ch_r;
  logic [CHUNK_W-1:0]    out_bytes_r;
  logic [COUNT_W-1:0]    out_cnt_r;
  logic                  out_last_r;
  logic [CNT32_W-1:0]    out_chtot_r;
  logic [CNT32_W-1:0]    out_frames_r;
  logic [CNT32_W-1:0]    out_inv_r;

  logic                  slot_free;
  logic                  in_fire;
  logic                  is_eos;
  logic [BYTE_W-1:0]     in_byte;
  logic [4:0]            hex_dec;
  logic                  check_ok;
  logic                  bad_chan;
  logic                  too_long;
  logic                  mem_wr;
  logic                  mem_rd;
  logic [CNT32_W-1:0]    frames_nxt;
  logic [CNT32_W-1:0]    invalid_nxt;
  logic [3:0]            chan_add;
  logic [CNT32_W-1:0]    chan_tot_nxt;
  logic                  fill_done;
  logic                  line_end;

  // Output slot frees up when empty or being taken this cycle
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;
  assign is_eos    = (in_tuser == IN_EOS);
  assign in_byte   = in_tdata;
  assign line_end  = (in_byte == LINE_END);

  // Check digit: legal hex and equal to the payload length mod 16
  assign hex_dec   = hex_decode(held_byte_r);
  assign check_ok  = held_valid_r && hex_dec[4] && (hex_dec[3:0] == len_r[3:0]);

  assign bad_chan  = (in_byte < ASCII_0) ||
                     ((in_byte - ASCII_0) > BYTE_W'(MAX_CHANNEL));
  assign too_long  = held_valid_r && (len_r >= LEN_W'(MAX_PAYLOAD));

  // Commit the held byte once a newer payload byte arrives
  assign mem_wr = in_fire && !is_eos && !line_end && !drop_line_r && have_chan_r &&
                  held_valid_r && !too_long;
  assign mem_rd = (state_r == S_FILL);

  assign frames_nxt  = sat_add(frames_r, 4'd1);
  assign invalid_nxt = sat_add(invalid_r, 4'd1);

  // Valid chunks count the payload bytes plus one, rejected ones the bytes alone
  assign chan_add     = emit_ok_r ? ({1'b0, fill_pos_r} + 4'd1) : {1'b0, fill_pos_r};
  assign chan_tot_nxt = sat_add(chan_cnt_r[emit_ch_r[CIDX_W-1:0]], chan_add);

  assign fill_done = (fill_pos_r == COUNT_W'(CHUNK_LEN - 1)) ||
                     ((fill_idx_r + LEN_W'(1)) == emit_len_r);

  // Single-port payload memory, registered read
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      payload_mem[len_r[ADDR_W-1:0]] <= held_byte_r;
    end else if (mem_rd) begin
      mem_q_r <= payload_mem[fill_idx_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      have_chan_r  <= 1'b0;
      chan_code_r  <= '0;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      drop_line_r  <= 1'b0;
      len_r        <= '0;
      frames_r     <= '0;
      invalid_r    <= '0;
      for (int i = 0; i < NCHAN; i++) begin
        chan_cnt_r[i] <= '0;
      end
      emit_len_r   <= '0;
      emit_ok_r    <= 1'b0;
      emit_ch_r    <= '0;
      fill_idx_r   <= '0;
      fill_pos_r   <= '0;
      land_r       <= 1'b0;
      land_pos_r   <= '0;
      chunk_r      <= ALL_PAD;
      out_valid_r  <= 1'b0;
    end else begin
      // Drop the result once taken; loads below override
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      // Place the byte read last cycle into the chunk
      land_r <= 1'b0;
      if (land_r) begin
        chunk_r[land_pos_r*BYTE_W +: BYTE_W] <= mem_q_r;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (is_eos || line_end) begin
              // Close the line in either case
              have_chan_r  <= 1'b0;
              chan_code_r  <= '0;
              held_byte_r  <= '0;
              held_valid_r <= 1'b0;
              drop_line_r  <= 1'b0;
              len_r        <= '0;
            end

            if (is_eos || (line_end && !have_chan_r)) begin
              // Stop result
              out_valid_r  <= 1'b1;
              out_kind_r   <= REC_STOP;
              out_ch_r     <= '0;
              out_bytes_r  <= ALL_PAD;
              out_cnt_r    <= '0;
              out_last_r   <= 1'b1;
              out_chtot_r  <= '0;
              out_frames_r <= frames_r;
              out_inv_r    <= invalid_r;
            end else if (line_end) begin
              frames_r <= frames_nxt;
              if (!drop_line_r) begin
                emit_len_r <= len_r;
                emit_ok_r  <= check_ok;
                emit_ch_r  <= check_ok ? chan_code_r : '0;
                fill_idx_r <= '0;
                fill_pos_r <= '0;
                chunk_r    <= ALL_PAD;
                if (!check_ok) begin
                  invalid_r <= invalid_nxt;
                end
                if (len_r != '0) begin
                  state_r <= S_FILL;
                end else if (!check_ok) begin
                  // Rejected line with no payload: one empty chunk
                  out_valid_r  <= 1'b1;
                  out_kind_r   <= REC_REJECTED;
                  out_ch_r     <= '0;
                  out_bytes_r  <= ALL_PAD;
                  out_cnt_r    <= '0;
                  out_last_r   <= 1'b1;
                  out_chtot_r  <= chan_cnt_r[0];
                  out_frames_r <= frames_nxt;
                  out_inv_r    <= invalid_nxt;
                end
              end
            end else if (drop_line_r) begin
              // Discard the rest of a flagged line
            end else if (!have_chan_r) begin
              have_chan_r <= 1'b1;
              if (bad_chan) begin
                drop_line_r  <= 1'b1;
                out_valid_r  <= 1'b1;
                out_kind_r   <= REC_BAD_CHAN;
                out_ch_r     <= '0;
                out_bytes_r  <= ALL_PAD;
                out_cnt_r    <= '0;
                out_last_r   <= 1'b1;
                out_chtot_r  <= '0;
                out_frames_r <= frames_r;
                out_inv_r    <= invalid_r;
              end else begin
                chan_code_r <= CHAN_W'(in_byte - ASCII_0);
              end
            end else if (too_long) begin
              drop_line_r  <= 1'b1;
              out_valid_r  <= 1'b1;
              out_kind_r   <= REC_TOO_LONG;
              out_ch_r     <= chan_code_r;
              out_bytes_r  <= ALL_PAD;
              out_cnt_r    <= '0;
              out_last_r   <= 1'b1;
              out_chtot_r  <= '0;
              out_frames_r <= frames_r;
              out_inv_r    <= invalid_r;
            end else begin
              // Hold the newest byte; it may turn out to be the check digit
              if (held_valid_r) begin
                len_r <= len_r + LEN_W'(1);
              end
              held_byte_r  <= in_byte;
              held_valid_r <= 1'b1;
            end
          end
        end

        S_FILL: begin
          // Issue one payload read per cycle
          land_r     <= 1'b1;
          land_pos_r <= fill_pos_r;
          fill_idx_r <= fill_idx_r + LEN_W'(1);
          fill_pos_r <= fill_pos_r + COUNT_W'(1);
          if (fill_done) begin
            state_r <= S_LAND;
          end
        end

        S_LAND: begin
          state_r <= S_PUSH;
        end

        S_PUSH: begin
          if (slot_free) begin
            chan_cnt_r[emit_ch_r[CIDX_W-1:0]] <= chan_tot_nxt;
            out_valid_r  <= 1'b1;
            out_kind_r   <= emit_ok_r ? REC_VALID : REC_REJECTED;
            out_ch_r     <= emit_ch_r;
            out_bytes_r  <= chunk_r;
            out_cnt_r    <= fill_pos_r;
            out_last_r   <= (fill_idx_r == emit_len_r);
            out_chtot_r  <= chan_tot_nxt;
            out_frames_r <= frames_r;
            out_inv_r    <= invalid_r;
            fill_pos_r   <= '0;
            chunk_r      <= ALL_PAD;
            state_r      <= (fill_idx_r == emit_len_r) ? S_IDLE : S_FILL;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_inv_r, out_frames_r, out_chtot_r, out_cnt_r,
                       out_bytes_r, out_ch_r};

endmodule

`default_nettype wire
